>>> rtl/vltc_pkg.sv
// ----------------------------------------------------------------------------
// Vehicle light timer controller package
// Sample and result types, register map and register reset values.
// ----------------------------------------------------------------------------
package vltc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_WINDOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_ONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_TWO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POST_IGNITION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_IDLE   = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0] BLINK_WINDOW_RST  = 16'd1200;
  localparam logic [CFG_W-1:0] FOLLOW_ONE_RST    = 16'd5000;
  localparam logic [CFG_W-1:0] FOLLOW_TWO_RST    = 16'd6000;
  localparam logic [CFG_W-1:0] POST_IGNITION_RST = 16'd7000;
  localparam logic [CFG_W-1:0] RELAY_MIN_RST     = 16'd2500;
  localparam logic [CFG_W-1:0] SIGNAL_IDLE_RST   = 16'd3000;

  // Pulse counter saturation value and the pulse counts that are judged
  localparam logic [1:0] PULSE_MAX = 2'd3;
  localparam logic [1:0] PULSE_ONE = 2'd1;
  localparam logic [1:0] PULSE_TWO = 2'd2;

  typedef struct packed {
    logic        ignition_on;
    logic        signal_on;
    logic [31:0] now_ms;
  } vltc_in_t;

  typedef struct packed {
    logic headlight_on;
    logic relay_on;
    logic follow_active;
    logic post_active;
  } vltc_out_t;

endpackage

>>> rtl/vehicle_light_timer_controller.sv
// ----------------------------------------------------------------------------
// Vehicle light timer controller
// Headlight hold, follow-me and turn-signal relay timing from sampled inputs.
// ----------------------------------------------------------------------------
// One sample is accepted per clock while in_stall is low. Each transaction
// lands in an input register, one pass of compare-and-update logic works it
// against the timer state, and the result is written to the output register
// together with the new state, so the throughput is one transaction per cycle
// unless out_stall holds the result register. The output register parts the
// two channels: a new sample is taken while a finished result still waits, and
// in_stall rises only when both registers are full and out_stall is high.
// Elapsed times are taken modulo 2^TIME_BITS. Configuration registers may be
// written at any time the block is idle; they reset to their nominal values.
module vehicle_light_timer_controller
  import vltc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vltc_in_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output vltc_out_t            out_data,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef logic [TIME_BITS-1:0] time_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] blink_window;
  logic [CFG_W-1:0] follow_one;
  logic [CFG_W-1:0] follow_two;
  logic [CFG_W-1:0] post_ignition;
  logic [CFG_W-1:0] relay_min;
  logic [CFG_W-1:0] signal_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_window  <= BLINK_WINDOW_RST;
      follow_one    <= FOLLOW_ONE_RST;
      follow_two    <= FOLLOW_TWO_RST;
      post_ignition <= POST_IGNITION_RST;
      relay_min     <= RELAY_MIN_RST;
      signal_idle   <= SIGNAL_IDLE_RST;
    end else if (cfg_write) begin
      // Indexes past the register map are dropped.
      case (cfg_index)
        REG_BLINK_WINDOW:  blink_window  <= cfg_data;
        REG_FOLLOW_ONE:    follow_one    <= cfg_data;
        REG_FOLLOW_TWO:    follow_two    <= cfg_data;
        REG_POST_IGNITION: post_ignition <= cfg_data;
        REG_RELAY_MIN:     relay_min     <= cfg_data;
        REG_SIGNAL_IDLE:   signal_idle   <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register and pipeline control
  // --------------------------------------------------------------------------
  logic     smp_valid;
  vltc_in_t smp;
  logic     advance;

  // Move the held sample into the result register whenever that register is
  // empty or being emptied this cycle.
  assign advance  = smp_valid && (!out_valid || !out_stall);
  assign in_stall = smp_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!in_stall) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      smp <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Timer state
  // --------------------------------------------------------------------------
  logic             prev_ignition,    prev_ignition_next;
  logic             prev_signal,      prev_signal_next;
  logic             post_running,     post_running_next;
  time_t            post_start,       post_start_next;
  logic             follow_running,   follow_running_next;
  time_t            follow_start,     follow_start_next;
  logic [CFG_W-1:0] follow_length,    follow_length_next;
  logic [1:0]       pulse_count,      pulse_count_next;
  time_t            last_pulse_time,  last_pulse_time_next;
  logic             relay_latched,    relay_latched_next;
  time_t            relay_start,      relay_start_next;
  time_t            last_signal_time, last_signal_time_next;

  logic  ign;
  logic  sig;
  time_t now;
  logic  sig_edge;

  assign ign      = smp.ignition_on;
  assign sig      = smp.signal_on;
  assign now      = TIME_BITS'(smp.now_ms);
  assign sig_edge = sig && !prev_signal;

  // One pass of the update rules, in the order they take effect.
  always_comb begin
    prev_ignition_next    = ign;
    prev_signal_next      = sig;
    post_running_next     = post_running;
    post_start_next       = post_start;
    follow_running_next   = follow_running;
    follow_start_next     = follow_start;
    follow_length_next    = follow_length;
    pulse_count_next      = pulse_count;
    last_pulse_time_next  = last_pulse_time;
    relay_latched_next    = relay_latched;
    relay_start_next      = relay_start;
    last_signal_time_next = last_signal_time;

    // Ignition on: drop both headlight timers.
    if (ign && !prev_ignition) begin
      follow_running_next = 1'b0;
      post_running_next   = 1'b0;
      follow_length_next  = '0;
    end
    // Ignition off: start the post-ignition hold.
    if (!ign && prev_ignition) begin
      post_start_next   = now;
      post_running_next = 1'b1;
    end
    if (post_running_next &&
        (time_t'(now - post_start_next) >= TIME_BITS'(post_ignition))) begin
      post_running_next = 1'b0;
    end

    if (!ign) begin
      // Count signal pulses, saturating.
      if (sig_edge) begin
        if (pulse_count_next != PULSE_MAX) begin
          pulse_count_next = pulse_count_next + 2'd1;
        end
        last_pulse_time_next = now;
      end
      // Judge the count once the window has gone quiet.
      if ((pulse_count_next != '0) &&
          (time_t'(now - last_pulse_time_next) > TIME_BITS'(blink_window))) begin
        unique case (pulse_count_next)
          PULSE_ONE: follow_length_next = follow_one;
          PULSE_TWO: follow_length_next = follow_two;
          default:   follow_length_next = '0;
        endcase
        if (follow_length_next != '0) begin
          follow_running_next = 1'b1;
          follow_start_next   = now;
        end
        pulse_count_next = '0;
      end
      if (follow_running_next &&
          (time_t'(now - follow_start_next) >= TIME_BITS'(follow_length_next))) begin
        follow_running_next = 1'b0;
        follow_length_next  = '0;
      end
    end

    // Relay: latch on an edge, refresh activity time on every edge.
    if (sig_edge) begin
      last_signal_time_next = now;
      if (!relay_latched_next) begin
        relay_latched_next = 1'b1;
        relay_start_next   = now;
      end
    end
    if (relay_latched_next &&
        (time_t'(now - relay_start_next) >= TIME_BITS'(relay_min)) &&
        (time_t'(now - last_signal_time_next) >= TIME_BITS'(signal_idle))) begin
      relay_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ignition    <= 1'b0;
      prev_signal      <= 1'b0;
      post_running     <= 1'b0;
      post_start       <= '0;
      follow_running   <= 1'b0;
      follow_start     <= '0;
      follow_length    <= '0;
      pulse_count      <= '0;
      last_pulse_time  <= '0;
      relay_latched    <= 1'b0;
      relay_start      <= '0;
      last_signal_time <= '0;
    end else if (advance) begin
      prev_ignition    <= prev_ignition_next;
      prev_signal      <= prev_signal_next;
      post_running     <= post_running_next;
      post_start       <= post_start_next;
      follow_running   <= follow_running_next;
      follow_start     <= follow_start_next;
      follow_length    <= follow_length_next;
      pulse_count      <= pulse_count_next;
      last_pulse_time  <= last_pulse_time_next;
      relay_latched    <= relay_latched_next;
      relay_start      <= relay_start_next;
      last_signal_time <= last_signal_time_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.headlight_on  <= ign || follow_running_next || post_running_next;
      out_data.relay_on      <= relay_latched_next;
      out_data.follow_active <= follow_running_next;
      out_data.post_active   <= post_running_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Any running headlight timer must show as a lit headlight.
  a_headlight_covers_timers: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.follow_active || out_data.post_active)
      |-> out_data.headlight_on)
    else $error("headlight off while a timer runs");

  // A running follow-me timer always has a nonzero length behind it.
  a_follow_has_length: assert property (@(posedge clk) disable iff (rst)
    follow_running |-> (follow_length != '0))
    else $error("follow-me running with zero length");

  // Timer state moves only when a transaction is worked.
  a_state_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pulse_count) && $stable(relay_latched)
      && $stable(follow_running) && $stable(post_running))
    else $error("timer state changed without a transaction");

endmodule
